// ===== rtl/cbo_pkg.sv =====
// shared types, widths and the arctangent table for the compass bearing core
// no dependencies

package cbo_pkg;

  localparam int unsigned InW         = 32;
  localparam int unsigned CordicStages = 32;
  localparam int unsigned TableSize   = 48;
  localparam int unsigned IdxW        = $clog2(TableSize);
  localparam int unsigned FracBits    = 24;
  // vector magnitude stays below 2^57 through every stage
  localparam int unsigned XyW         = 58;
  // +-(90 + 99.9) degrees with 24 fractional bits
  localparam int unsigned AccW        = 33;
  localparam int unsigned BearingW    = 9;
  localparam int unsigned DegW        = 11;
  localparam int unsigned FullTurn    = 360;
  localparam int unsigned Latency     = CordicStages + 2;

  localparam logic signed [AccW-1:0] Deg90Q24 = AccW'(90 * (2 ** FracBits));

  typedef struct packed {
    logic                   zero;
    logic signed [XyW-1:0]  x;
    logic signed [XyW-1:0]  y;
    logic signed [AccW-1:0] acc;
  } lane_t;

  // atan(2^-i) in degrees, scaled by 2^24
  function automatic logic signed [AccW-1:0] angle_at(input logic [IdxW-1:0] idx);
    logic signed [AccW-1:0] a;
    a = '0;
    case (idx)
      6'd0:  a = AccW'(754974720);
      6'd1:  a = AccW'(445687602);
      6'd2:  a = AccW'(235489088);
      6'd3:  a = AccW'(119537938);
      6'd4:  a = AccW'(60000934);
      6'd5:  a = AccW'(30029717);
      6'd6:  a = AccW'(15018523);
      6'd7:  a = AccW'(7509720);
      6'd8:  a = AccW'(3754917);
      6'd9:  a = AccW'(1877466);
      6'd10: a = AccW'(938734);
      6'd11: a = AccW'(469367);
      6'd12: a = AccW'(234684);
      6'd13: a = AccW'(117342);
      6'd14: a = AccW'(58671);
      6'd15: a = AccW'(29335);
      6'd16: a = AccW'(14668);
      6'd17: a = AccW'(7334);
      6'd18: a = AccW'(3667);
      6'd19: a = AccW'(1833);
      6'd20: a = AccW'(917);
      6'd21: a = AccW'(458);
      6'd22: a = AccW'(229);
      6'd23: a = AccW'(115);
      6'd24: a = AccW'(57);
      6'd25: a = AccW'(29);
      6'd26: a = AccW'(14);
      6'd27: a = AccW'(7);
      6'd28: a = AccW'(4);
      6'd29: a = AccW'(2);
      6'd30: a = AccW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/compass_bearing_from_offset_core.sv =====
// compass bearing core: entry cell, a row of cordic cells, rounding cell
// depends on cbo_pkg, cbo_prerot, cbo_cell and cbo_round
//
//   channel   signals                          direction  handshake
//   request   start_i, offset_x_i, offset_y_i  in         start_i & !busy_o
//   result    done_o, bearing_o                out        one-cycle strobe
//
// one request per clock, every clock: busy_o stays low
// a request passes in turn through the registered entry cell, one cell per micro-rotation
// and the rounding cell
// reset clears only the valid bits travelling with the data
// the receiver cannot stall, so nothing ever holds the row

module compass_bearing_from_offset_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [cbo_pkg::InW-1:0]      offset_x_i,
  input  logic signed [cbo_pkg::InW-1:0]      offset_y_i,
  output logic                                done_o,
  output logic [cbo_pkg::BearingW-1:0]        bearing_o
);

  localparam int unsigned N = cbo_pkg::CordicStages;

  logic           valid_c [N+1];
  cbo_pkg::lane_t lane_c  [N+1];
  logic           req_acc;

  assign busy_o  = 1'b0;
  assign req_acc = start_i && !busy_o;

  cbo_prerot u_prerot (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (req_acc),
    .offset_x_i (offset_x_i),
    .offset_y_i (offset_y_i),
    .valid_o    (valid_c[0]),
    .lane_o     (lane_c[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    cbo_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .stage_i (cbo_pkg::IdxW'(i)),
      .valid_i (valid_c[i]),
      .lane_i  (lane_c[i]),
      .valid_o (valid_c[i+1]),
      .lane_o  (lane_c[i+1])
    );
  end

  cbo_round u_round (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (valid_c[N]),
    .lane_i    (lane_c[N]),
    .done_o    (done_o),
    .bearing_o (bearing_o)
  );

  a_req_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |-> ##(cbo_pkg::Latency) done_o)
    else $error("request lost in the cell row");

  a_result_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(req_acc, cbo_pkg::Latency))
    else $error("result without a request");

  a_bearing_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (bearing_o < cbo_pkg::BearingW'(cbo_pkg::FullTurn)))
    else $error("bearing out of 0..359");

  a_zero_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_acc && offset_x_i == '0 && offset_y_i == '0)
      |-> ##(cbo_pkg::Latency) (bearing_o == '0))
    else $error("zero offset did not give bearing 0");

endmodule

// ===== rtl/cbo_prerot.sv =====
// entry cell: swaps the offset into vector form, folds the left half-plane
// by +-90 degrees and scales by 2^24; depends on cbo_pkg

module cbo_prerot (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic signed [cbo_pkg::InW-1:0] offset_x_i,
  input  logic signed [cbo_pkg::InW-1:0] offset_y_i,
  output logic                           valid_o,
  output cbo_pkg::lane_t                 lane_o
);

  localparam int unsigned W = cbo_pkg::InW + 1;

  logic signed [W-1:0] x0, y0, xr, yr;
  logic signed [cbo_pkg::AccW-1:0] acc0;
  logic valid_q;
  cbo_pkg::lane_t lane_d, lane_q;

  always_comb begin
    x0   = -W'(offset_y_i);
    y0   = W'(offset_x_i);
    xr   = x0;
    yr   = y0;
    acc0 = '0;
    if (x0 < 0) begin
      if (y0 >= 0) begin
        xr   = y0;
        yr   = -x0;
        acc0 = cbo_pkg::Deg90Q24;
      end else begin
        xr   = -y0;
        yr   = x0;
        acc0 = -cbo_pkg::Deg90Q24;
      end
    end
    lane_d.zero = (offset_x_i == '0) && (offset_y_i == '0);
    lane_d.x    = cbo_pkg::XyW'(xr) <<< cbo_pkg::FracBits;
    lane_d.y    = cbo_pkg::XyW'(yr) <<< cbo_pkg::FracBits;
    lane_d.acc  = acc0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

// ===== rtl/cbo_cell.sv =====
// one cordic vectoring micro-rotation with its pipeline register
// depends on cbo_pkg for the lane type and the arctangent table

module cbo_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [cbo_pkg::IdxW-1:0]    stage_i,
  input  logic                        valid_i,
  input  cbo_pkg::lane_t              lane_i,
  output logic                        valid_o,
  output cbo_pkg::lane_t              lane_o
);

  logic signed [cbo_pkg::XyW-1:0]  xs, ys;
  logic signed [cbo_pkg::AccW-1:0] ang;
  logic valid_q;
  cbo_pkg::lane_t lane_d, lane_q;

  always_comb begin
    // stage index is tied per cell, so the shifters reduce to wiring
    xs     = lane_i.x >>> stage_i;
    ys     = lane_i.y >>> stage_i;
    ang    = cbo_pkg::angle_at(stage_i);
    lane_d = lane_i;
    if (lane_i.y >= 0) begin
      lane_d.x   = lane_i.x + ys;
      lane_d.y   = lane_i.y - xs;
      lane_d.acc = lane_i.acc + ang;
    end else begin
      lane_d.x   = lane_i.x - ys;
      lane_d.y   = lane_i.y + xs;
      lane_d.acc = lane_i.acc - ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= lane_d;
  end

  assign valid_o = valid_q;
  assign lane_o  = lane_q;

endmodule

// ===== rtl/cbo_round.sv =====
// exit cell: rounds the angle to whole degrees, ties away from zero,
// and wraps into 0..359; depends on cbo_pkg

module cbo_round (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  cbo_pkg::lane_t                  lane_i,
  output logic                            done_o,
  output logic [cbo_pkg::BearingW-1:0]    bearing_o
);

  localparam int unsigned DW = cbo_pkg::DegW;

  logic [cbo_pkg::AccW-1:0]  mag, mag_rnd;
  logic signed [DW-1:0]      deg, deg_w;
  logic                      done_q;
  logic [cbo_pkg::BearingW-1:0] bearing_d, bearing_q;

  always_comb begin
    mag     = lane_i.acc[cbo_pkg::AccW-1] ? -lane_i.acc : lane_i.acc;
    mag_rnd = mag + cbo_pkg::AccW'(2 ** (cbo_pkg::FracBits - 1));
    deg     = DW'(mag_rnd >> cbo_pkg::FracBits);
    if (lane_i.acc[cbo_pkg::AccW-1]) begin
      deg = -deg;
    end
    deg_w = deg;
    if (deg < 0) begin
      deg_w = deg + DW'(cbo_pkg::FullTurn);
    end else if (deg >= DW'(cbo_pkg::FullTurn)) begin
      deg_w = deg - DW'(cbo_pkg::FullTurn);
    end
    bearing_d = lane_i.zero ? '0 : deg_w[cbo_pkg::BearingW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    bearing_q <= bearing_d;
  end

  assign done_o    = done_q;
  assign bearing_o = bearing_q;

endmodule
